### design/djkm_pkg.sv
// ----------------------------------------------------------------------------
// djkm_pkg
// Shared types, register map and constants for the dual joystick key and
// mouse mapper.
// ----------------------------------------------------------------------------
package djkm_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int HYST_W   = 10;
    localparam int GAIN_W   = 8;
    localparam int STEP_W   = 8;
    localparam int NUM_KEYS = 5;
    localparam int SMOOTH_W = 24;

    // apb port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register indexes
    localparam logic [2:0] REG_LEFT_X_CENTER  = 3'd0;
    localparam logic [2:0] REG_LEFT_Y_CENTER  = 3'd1;
    localparam logic [2:0] REG_RIGHT_X_CENTER = 3'd2;
    localparam logic [2:0] REG_RIGHT_Y_CENTER = 3'd3;
    localparam logic [2:0] REG_KEY_THRESHOLD  = 3'd4;
    localparam logic [2:0] REG_KEY_HYSTERESIS = 3'd5;
    localparam logic [2:0] REG_DEAD_ZONE      = 3'd6;
    localparam logic [2:0] REG_MOUSE_GAIN     = 3'd7;

    // register reset values
    localparam logic [SAMPLE_W-1:0] CENTER_RST    = 12'd1900;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd500;
    localparam logic [HYST_W-1:0]   HYSTERESIS_RST = 10'd80;
    localparam logic [SAMPLE_W-1:0] DEAD_ZONE_RST = 12'd300;
    localparam logic [GAIN_W-1:0]   GAIN_RST      = 8'd12;

    // gain scale: raw = floor(mag * gain * M / 2^25), M = ceil(2^30 / 25),
    // exact for mag * gain * 32 below 2^25
    localparam int GAIN_SCALE_W = 34;
    localparam int GAIN_SHIFT   = 25;
    localparam logic [GAIN_SCALE_W-1:0] GAIN_RECIP = 34'd42949673;
    localparam logic [GAIN_SCALE_W-1:0] GAIN_SCALE_RST =
        34'(GAIN_RST) * GAIN_RECIP;

    // key levels need room for center plus threshold plus hysteresis, signed
    localparam int LEVEL_W = 15;

    // key bit positions in the change mask
    localparam int KEY_UP    = 0;
    localparam int KEY_LEFT  = 1;
    localparam int KEY_DOWN  = 2;
    localparam int KEY_RIGHT = 3;
    localparam int KEY_JUMP  = 4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left_x;
        logic [SAMPLE_W-1:0] left_y;
        logic [SAMPLE_W-1:0] right_x;
        logic [SAMPLE_W-1:0] right_y;
        logic                button_pressed;
    } sample_t;

    typedef struct packed {
        logic                     up_held;
        logic                     left_held;
        logic                     down_held;
        logic                     right_held;
        logic                     jump_held;
        logic [NUM_KEYS-1:0]      key_change_mask;
        logic signed [STEP_W-1:0] mouse_dx;
        logic signed [STEP_W-1:0] mouse_dy;
        logic                     mouse_move;
    } result_t;

    // key that presses above a level and releases below another
    function automatic logic hyst_high(input logic held,
                                       input logic signed [LEVEL_W-1:0] v,
                                       input logic signed [LEVEL_W-1:0] press,
                                       input logic signed [LEVEL_W-1:0] release_lvl);
        logic r;
        r = held;
        if (v > press && !held)
        begin
            r = 1'b1;
        end
        else if (v < release_lvl && held)
        begin
            r = 1'b0;
        end
        return r;
    endfunction

    // key that presses below a level and releases above another
    function automatic logic hyst_low(input logic held,
                                      input logic signed [LEVEL_W-1:0] v,
                                      input logic signed [LEVEL_W-1:0] press,
                                      input logic signed [LEVEL_W-1:0] release_lvl);
        logic r;
        r = held;
        if (v < press && !held)
        begin
            r = 1'b1;
        end
        else if (v > release_lvl && held)
        begin
            r = 1'b0;
        end
        return r;
    endfunction

endpackage

### design/djkm_mouse_axis.sv
// ----------------------------------------------------------------------------
// djkm_mouse_axis
// One camera axis: dead zone, gain scaling, smoothing filter and rounding
// to a saturated mouse step. Holds the filter state of the axis.
// ----------------------------------------------------------------------------
module djkm_mouse_axis #(
    parameter int MAX_STEP = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   update,
    input  logic [djkm_pkg::SAMPLE_W-1:0]          sample,
    input  logic [djkm_pkg::SAMPLE_W-1:0]          center,
    input  logic [djkm_pkg::SAMPLE_W-1:0]          dead_zone,
    input  logic [djkm_pkg::GAIN_SCALE_W-1:0]      gain_scale,
    output logic signed [djkm_pkg::STEP_W-1:0]     step
);
    import djkm_pkg::*;

    localparam int DELTA_W = SAMPLE_W + 1;
    localparam int PROD_W  = SAMPLE_W + GAIN_SCALE_W;
    localparam int RAW_W   = PROD_W - GAIN_SHIFT;
    localparam int SUM_W   = SMOOTH_W + 3;
    localparam int RND_W   = SMOOTH_W + 1;
    localparam logic [RND_W-1:0] HALF_LSB = RND_W'(128);
    localparam logic [RND_W-9:0] STEP_MAX = (RND_W-8)'(MAX_STEP);

    logic signed [SMOOTH_W-1:0] smooth_reg;
    logic signed [SMOOTH_W-1:0] smooth_next;

    logic signed [DELTA_W-1:0]  delta;
    logic                       neg;
    logic [SAMPLE_W-1:0]        mag;
    logic [PROD_W-1:0]          prod;
    logic [RAW_W-1:0]           raw_mag;
    logic signed [RAW_W:0]      raw;
    logic signed [SUM_W-1:0]    f_ext;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-1:0]    sum_sh;
    logic [SMOOTH_W-1:0]        f_mag;
    logic [RND_W-1:0]           rnd;
    logic [RND_W-9:0]           whole;
    logic [RND_W-9:0]           sat;

    // signed delta and its magnitude
    assign delta = $signed({1'b0, sample}) - $signed({1'b0, center});
    assign neg   = delta[DELTA_W-1];
    assign mag   = neg ? SAMPLE_W'(-delta) : delta[SAMPLE_W-1:0];

    // gain * 256 / 200 as one multiply by the precomputed scale
    assign prod    = PROD_W'(mag) * PROD_W'(gain_scale);
    assign raw_mag = (mag < dead_zone) ? '0 : prod[PROD_W-1:GAIN_SHIFT];
    assign raw     = neg ? -$signed({1'b0, raw_mag}) : $signed({1'b0, raw_mag});

    // f <- floor((3f + raw) / 4)
    assign f_ext       = SUM_W'(smooth_reg);
    assign sum         = (f_ext <<< 1) + f_ext + SUM_W'(raw);
    assign sum_sh      = sum >>> 2;
    assign smooth_next = sum_sh[SMOOTH_W-1:0];

    // round half away from zero, saturate
    assign f_mag = smooth_next[SMOOTH_W-1] ? SMOOTH_W'(-smooth_next)
                                           : smooth_next;
    assign rnd   = RND_W'(f_mag) + HALF_LSB;
    assign whole = rnd[RND_W-1:8];
    assign sat   = (whole > STEP_MAX) ? STEP_MAX : whole;
    assign step  = smooth_next[SMOOTH_W-1] ? -$signed(STEP_W'(sat))
                                           : $signed(STEP_W'(sat));

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= '0;
        end
        else if (update)
        begin
            smooth_reg <= smooth_next;
        end
    end

endmodule

### design/dual_joystick_key_and_mouse_mapper_top.sv
// ----------------------------------------------------------------------------
// dual_joystick_key_and_mouse_mapper_top
// Maps movement stick axes to held direction keys with hysteresis, the stick
// button to a jump key, and camera stick axes to smoothed mouse steps.
// ----------------------------------------------------------------------------
// One result item for every sample item. A sample is taken into an input
// register, and one registered pass computes the keys, the change mask and
// the filtered mouse steps into the result register, so a new sample can be
// taken every cycle unless the result side stalls. The throughput of one
// item per cycle is set by that single pass: the key state loops through
// the hysteresis compares and the filter state through its add and shift,
// while the gain multiplier works on the sample alone. The result register
// lets the next sample be taken while a result waits. Registers sit on an
// APB port at byte address 4*index; the user must write them only while no
// item is in flight, and the block itself does not enforce it.
module dual_joystick_key_and_mouse_mapper_top #(
    parameter int MAX_STEP    = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample channel
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  djkm_pkg::sample_t             sample,
    // result channel
    output logic                          result_valid,
    input  logic                          result_ready,
    output djkm_pkg::result_t             result,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [djkm_pkg::ADDR_W-1:0]   paddr,
    input  logic [djkm_pkg::DATA_W-1:0]   pwdata,
    output logic [djkm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import djkm_pkg::*;

    localparam int MASK_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((33'd1 << MASK_BITS) - 33'd1);

    // configuration registers
    logic [SAMPLE_W-1:0]     left_x_center_reg;
    logic [SAMPLE_W-1:0]     left_y_center_reg;
    logic [SAMPLE_W-1:0]     right_x_center_reg;
    logic [SAMPLE_W-1:0]     right_y_center_reg;
    logic [SAMPLE_W-1:0]     key_threshold_reg;
    logic [HYST_W-1:0]       key_hysteresis_reg;
    logic [SAMPLE_W-1:0]     dead_zone_reg;
    logic [GAIN_W-1:0]       mouse_gain_reg;
    logic [GAIN_SCALE_W-1:0] gain_scale_reg;
    logic [GAIN_SCALE_W-1:0] gain_scale_next;

    logic       cfg_write;
    logic [2:0] cfg_index;

    // pipeline
    logic    in_valid_reg;
    sample_t in_item_reg;
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    advance;

    logic [NUM_KEYS-1:0] key_state_reg;
    logic [NUM_KEYS-1:0] key_state_next;

    logic [SAMPLE_W-1:0] lx;
    logic [SAMPLE_W-1:0] ly;
    logic [SAMPLE_W-1:0] rx;
    logic [SAMPLE_W-1:0] ry;

    logic signed [LEVEL_W-1:0] lx_s;
    logic signed [LEVEL_W-1:0] ly_s;
    logic signed [LEVEL_W-1:0] xc_s;
    logic signed [LEVEL_W-1:0] yc_s;
    logic signed [LEVEL_W-1:0] th_s;
    logic signed [LEVEL_W-1:0] hy_s;

    logic signed [STEP_W-1:0] dx;
    logic signed [STEP_W-1:0] dy;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    assign gain_scale_next = GAIN_SCALE_W'(pwdata[GAIN_W-1:0]) * GAIN_RECIP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_x_center_reg  <= CENTER_RST;
            left_y_center_reg  <= CENTER_RST;
            right_x_center_reg <= CENTER_RST;
            right_y_center_reg <= CENTER_RST;
            key_threshold_reg  <= THRESHOLD_RST;
            key_hysteresis_reg <= HYSTERESIS_RST;
            dead_zone_reg      <= DEAD_ZONE_RST;
            mouse_gain_reg     <= GAIN_RST;
            gain_scale_reg     <= GAIN_SCALE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LEFT_X_CENTER:  left_x_center_reg  <= pwdata[SAMPLE_W-1:0];
                REG_LEFT_Y_CENTER:  left_y_center_reg  <= pwdata[SAMPLE_W-1:0];
                REG_RIGHT_X_CENTER: right_x_center_reg <= pwdata[SAMPLE_W-1:0];
                REG_RIGHT_Y_CENTER: right_y_center_reg <= pwdata[SAMPLE_W-1:0];
                REG_KEY_THRESHOLD:  key_threshold_reg  <= pwdata[SAMPLE_W-1:0];
                REG_KEY_HYSTERESIS: key_hysteresis_reg <= pwdata[HYST_W-1:0];
                REG_DEAD_ZONE:      dead_zone_reg      <= pwdata[SAMPLE_W-1:0];
                REG_MOUSE_GAIN:
                begin
                    mouse_gain_reg <= pwdata[GAIN_W-1:0];
                    gain_scale_reg <= gain_scale_next;
                end
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_index)
            REG_LEFT_X_CENTER:  prdata = DATA_W'(left_x_center_reg);
            REG_LEFT_Y_CENTER:  prdata = DATA_W'(left_y_center_reg);
            REG_RIGHT_X_CENTER: prdata = DATA_W'(right_x_center_reg);
            REG_RIGHT_Y_CENTER: prdata = DATA_W'(right_y_center_reg);
            REG_KEY_THRESHOLD:  prdata = DATA_W'(key_threshold_reg);
            REG_KEY_HYSTERESIS: prdata = DATA_W'(key_hysteresis_reg);
            REG_DEAD_ZONE:      prdata = DATA_W'(dead_zone_reg);
            REG_MOUSE_GAIN:     prdata = DATA_W'(mouse_gain_reg);
            default:            prdata = '0;
        endcase
    end

    // handshake: the input register moves on whenever the result register frees
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_state_reg <= '0;
        end
        else
        begin
            if (sample_ready)
            begin
                in_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                key_state_reg <= key_state_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            in_item_reg <= sample;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // samples limited to the converter width
    assign lx = in_item_reg.left_x  & SAMPLE_MASK;
    assign ly = in_item_reg.left_y  & SAMPLE_MASK;
    assign rx = in_item_reg.right_x & SAMPLE_MASK;
    assign ry = in_item_reg.right_y & SAMPLE_MASK;

    // key levels as exact signed values
    assign lx_s = $signed(LEVEL_W'(lx));
    assign ly_s = $signed(LEVEL_W'(ly));
    assign xc_s = $signed(LEVEL_W'(left_x_center_reg));
    assign yc_s = $signed(LEVEL_W'(left_y_center_reg));
    assign th_s = $signed(LEVEL_W'(key_threshold_reg));
    assign hy_s = $signed(LEVEL_W'(key_hysteresis_reg));

    // direction keys with hysteresis, jump follows the button
    always_comb
    begin
        key_state_next[KEY_UP] = hyst_high(key_state_reg[KEY_UP], ly_s,
                                           yc_s + th_s + hy_s, yc_s + th_s - hy_s);
        key_state_next[KEY_DOWN] = hyst_low(key_state_reg[KEY_DOWN], ly_s,
                                            yc_s - th_s - hy_s, yc_s - th_s + hy_s);
        key_state_next[KEY_LEFT] = hyst_low(key_state_reg[KEY_LEFT], lx_s,
                                            xc_s - th_s - hy_s, xc_s - th_s + hy_s);
        key_state_next[KEY_RIGHT] = hyst_high(key_state_reg[KEY_RIGHT], lx_s,
                                              xc_s + th_s + hy_s, xc_s + th_s - hy_s);
        key_state_next[KEY_JUMP] = in_item_reg.button_pressed;
    end

    // camera axes
    djkm_mouse_axis #(
        .MAX_STEP (MAX_STEP)
    ) u_axis_x (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (advance),
        .sample     (rx),
        .center     (right_x_center_reg),
        .dead_zone  (dead_zone_reg),
        .gain_scale (gain_scale_reg),
        .step       (dx)
    );

    djkm_mouse_axis #(
        .MAX_STEP (MAX_STEP)
    ) u_axis_y (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (advance),
        .sample     (ry),
        .center     (right_y_center_reg),
        .dead_zone  (dead_zone_reg),
        .gain_scale (gain_scale_reg),
        .step       (dy)
    );

    // result assembly
    always_comb
    begin
        result_next.up_held         = key_state_next[KEY_UP];
        result_next.left_held       = key_state_next[KEY_LEFT];
        result_next.down_held       = key_state_next[KEY_DOWN];
        result_next.right_held      = key_state_next[KEY_RIGHT];
        result_next.jump_held       = key_state_next[KEY_JUMP];
        result_next.key_change_mask = key_state_next ^ key_state_reg;
        result_next.mouse_dx        = dx;
        result_next.mouse_dy        = dy;
        result_next.mouse_move      = (dx != '0) || (dy != '0);
    end

    // checks
    a_held_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result_reg.up_held == key_state_reg[KEY_UP])
            && (result_reg.left_held == key_state_reg[KEY_LEFT])
            && (result_reg.down_held == key_state_reg[KEY_DOWN])
            && (result_reg.right_held == key_state_reg[KEY_RIGHT])
            && (result_reg.jump_held == key_state_reg[KEY_JUMP]))
        else $error("held keys differ from key state");

    a_step_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_reg.mouse_dx <= $signed(STEP_W'(MAX_STEP)))
            && (result_reg.mouse_dx >= -$signed(STEP_W'(MAX_STEP)))
            && (result_reg.mouse_dy <= $signed(STEP_W'(MAX_STEP)))
            && (result_reg.mouse_dy >= -$signed(STEP_W'(MAX_STEP))))
        else $error("mouse step beyond limit");

    a_move_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> result_reg.mouse_move
            == ((result_reg.mouse_dx != '0) || (result_reg.mouse_dy != '0)))
        else $error("mouse move flag inconsistent");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready && in_valid_reg) |-> advance)
        else $error("input register overwritten while held");

endmodule

### dv/djkm_checker.sv
// ----------------------------------------------------------------------------
// djkm_checker
// Watches the sample, result and register ports of the joystick mapper,
// keeps its own copy of the key, filter and register state, works out the
// result item for every accepted sample item and compares each accepted
// result item field by field in order. Register reads are checked too.
// ----------------------------------------------------------------------------
module djkm_checker #(
    parameter int MAX_STEP    = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_valid,
    input  logic                        sample_ready,
    input  djkm_pkg::sample_t           sample,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  djkm_pkg::result_t           result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [djkm_pkg::ADDR_W-1:0] paddr,
    input  logic [djkm_pkg::DATA_W-1:0] pwdata,
    input  logic [djkm_pkg::DATA_W-1:0] prdata,
    input  logic                        pready,
    output int                          fail_count,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import djkm_pkg::*;

    localparam longint RAW_MAX      = 64'sd8388607;
    localparam int     REPORT_LIMIT = 10;

    // register copies
    logic [SAMPLE_W-1:0] lx_center;
    logic [SAMPLE_W-1:0] ly_center;
    logic [SAMPLE_W-1:0] rx_center;
    logic [SAMPLE_W-1:0] ry_center;
    logic [SAMPLE_W-1:0] key_threshold;
    logic [HYST_W-1:0]   key_hysteresis;
    logic [SAMPLE_W-1:0] dead_zone;
    logic [GAIN_W-1:0]   mouse_gain;
    logic [DATA_W-1:0]   reg_value;

    // key and filter state
    logic [NUM_KEYS-1:0] held_keys;
    longint              smooth_x;
    longint              smooth_y;

    result_t             expected_results [$];

    // key pressed above one level, released below another
    function automatic logic key_above(logic held, longint v, longint press_lvl,
                                       longint release_lvl);
        if (v > press_lvl && !held)
        begin
            return 1'b1;
        end
        if (v < release_lvl && held)
        begin
            return 1'b0;
        end
        return held;
    endfunction

    // key pressed below one level, released above another
    function automatic logic key_below(logic held, longint v, longint press_lvl,
                                       longint release_lvl);
        if (v < press_lvl && !held)
        begin
            return 1'b1;
        end
        if (v > release_lvl && held)
        begin
            return 1'b0;
        end
        return held;
    endfunction

    // dead zone, then gain/200 in q.8 truncated toward zero, then bounded
    function automatic longint scaled_delta(longint d);
        longint mag;
        longint r;
        mag = (d < 0) ? -d : d;
        if (mag < longint'(dead_zone))
        begin
            return 0;
        end
        r = (mag * longint'(mouse_gain) * 256) / 200;
        if (r > RAW_MAX)
        begin
            r = RAW_MAX;
        end
        return (d < 0) ? -r : r;
    endfunction

    // round half away from zero to whole steps, bounded by max step
    function automatic logic signed [STEP_W-1:0] mouse_step(longint f);
        longint mag;
        longint st;
        mag = (f < 0) ? -f : f;
        st  = (mag + 128) >>> 8;
        if (st > MAX_STEP)
        begin
            st = MAX_STEP;
        end
        return STEP_W'((f < 0) ? -st : st);
    endfunction

    // next result item for one sample item, advancing the state
    function automatic result_t predict_result(sample_t s);
        longint              smask;
        longint              lx;
        longint              ly;
        longint              rx;
        longint              ry;
        longint              th;
        longint              hy;
        longint              xc;
        longint              yc;
        logic [NUM_KEYS-1:0] next_keys;
        result_t             r;
        smask = (longint'(1) << SAMPLE_BITS) - 1;
        lx    = longint'(s.left_x) & smask;
        ly    = longint'(s.left_y) & smask;
        rx    = longint'(s.right_x) & smask;
        ry    = longint'(s.right_y) & smask;
        th    = longint'(key_threshold);
        hy    = longint'(key_hysteresis);
        xc    = longint'(lx_center);
        yc    = longint'(ly_center);

        next_keys[KEY_UP]    = key_above(held_keys[KEY_UP], ly, yc + th + hy, yc + th - hy);
        next_keys[KEY_DOWN]  = key_below(held_keys[KEY_DOWN], ly, yc - th - hy, yc - th + hy);
        next_keys[KEY_LEFT]  = key_below(held_keys[KEY_LEFT], lx, xc - th - hy, xc - th + hy);
        next_keys[KEY_RIGHT] = key_above(held_keys[KEY_RIGHT], lx, xc + th + hy, xc + th - hy);
        next_keys[KEY_JUMP]  = s.button_pressed;

        r.up_held         = next_keys[KEY_UP];
        r.left_held       = next_keys[KEY_LEFT];
        r.down_held       = next_keys[KEY_DOWN];
        r.right_held      = next_keys[KEY_RIGHT];
        r.jump_held       = next_keys[KEY_JUMP];
        r.key_change_mask = next_keys ^ held_keys;
        held_keys         = next_keys;

        // smoothing filter, floor of (3f + raw) / 4
        smooth_x = (3 * smooth_x + scaled_delta(rx - longint'(rx_center))) >>> 2;
        smooth_y = (3 * smooth_y + scaled_delta(ry - longint'(ry_center))) >>> 2;

        r.mouse_dx   = mouse_step(smooth_x);
        r.mouse_dy   = mouse_step(smooth_y);
        r.mouse_move = (r.mouse_dx != 0) || (r.mouse_dy != 0);
        return r;
    endfunction

    function automatic string fmt_result(result_t r);
        return $sformatf("up %b left %b down %b right %b jump %b mask %b dx %0d dy %0d move %b",
                         r.up_held, r.left_held, r.down_held, r.right_held, r.jump_held,
                         r.key_change_mask, $signed(r.mouse_dx), $signed(r.mouse_dy),
                         r.mouse_move);
    endfunction

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // compare against the oldest expected item
    task automatic check_result(result_t got);
        result_t want;
        string   bad;
        if (expected_results.size() == 0)
        begin
            note_failure({"result item with no sample pending: ", fmt_result(got)});
            return;
        end
        want = expected_results.pop_front();
        bad  = "";
        if (got.up_held !== want.up_held) bad = {bad, " up_held"};
        if (got.left_held !== want.left_held) bad = {bad, " left_held"};
        if (got.down_held !== want.down_held) bad = {bad, " down_held"};
        if (got.right_held !== want.right_held) bad = {bad, " right_held"};
        if (got.jump_held !== want.jump_held) bad = {bad, " jump_held"};
        if (got.key_change_mask !== want.key_change_mask) bad = {bad, " key_change_mask"};
        if (got.mouse_dx !== want.mouse_dx) bad = {bad, " mouse_dx"};
        if (got.mouse_dy !== want.mouse_dy) bad = {bad, " mouse_dy"};
        if (got.mouse_move !== want.mouse_move) bad = {bad, " mouse_move"};
        if (bad != "")
        begin
            note_failure($sformatf("wrong%s\n    expected %s\n    actual   %s",
                                   bad, fmt_result(want), fmt_result(got)));
        end
    endtask

    // watch all three ports
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_center      = CENTER_RST;
            ly_center      = CENTER_RST;
            rx_center      = CENTER_RST;
            ry_center      = CENTER_RST;
            key_threshold  = THRESHOLD_RST;
            key_hysteresis = HYSTERESIS_RST;
            dead_zone      = DEAD_ZONE_RST;
            mouse_gain     = GAIN_RST;
            held_keys      = '0;
            smooth_x       = 0;
            smooth_y       = 0;
            fail_count     = 0;
            pending        = 0;
            expected_results.delete();
        end
        else
        begin
            // register writes and read-backs
            if (psel && penable && pready && pwrite)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_LEFT_X_CENTER:  lx_center      = pwdata[SAMPLE_W-1:0];
                    REG_LEFT_Y_CENTER:  ly_center      = pwdata[SAMPLE_W-1:0];
                    REG_RIGHT_X_CENTER: rx_center      = pwdata[SAMPLE_W-1:0];
                    REG_RIGHT_Y_CENTER: ry_center      = pwdata[SAMPLE_W-1:0];
                    REG_KEY_THRESHOLD:  key_threshold  = pwdata[SAMPLE_W-1:0];
                    REG_KEY_HYSTERESIS: key_hysteresis = pwdata[HYST_W-1:0];
                    REG_DEAD_ZONE:      dead_zone      = pwdata[SAMPLE_W-1:0];
                    REG_MOUSE_GAIN:     mouse_gain     = pwdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            else if (psel && penable && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_LEFT_X_CENTER:  reg_value = DATA_W'(lx_center);
                    REG_LEFT_Y_CENTER:  reg_value = DATA_W'(ly_center);
                    REG_RIGHT_X_CENTER: reg_value = DATA_W'(rx_center);
                    REG_RIGHT_Y_CENTER: reg_value = DATA_W'(ry_center);
                    REG_KEY_THRESHOLD:  reg_value = DATA_W'(key_threshold);
                    REG_KEY_HYSTERESIS: reg_value = DATA_W'(key_hysteresis);
                    REG_DEAD_ZONE:      reg_value = DATA_W'(dead_zone);
                    default:            reg_value = DATA_W'(mouse_gain);
                endcase
                if (prdata !== reg_value)
                begin
                    note_failure($sformatf("register read at 0x%0h: expected %0d actual %0d",
                                           paddr, reg_value, prdata));
                end
            end

            // result items out, then sample items in
            if (result_valid && result_ready)
            begin
                check_result(result);
            end
            if (sample_valid && sample_ready)
            begin
                expected_results.push_back(predict_result(sample));
            end
            pending = expected_results.size();
        end
    end

endmodule

### dv/tb_dual_joystick_key_and_mouse_mapper_top.sv
// ----------------------------------------------------------------------------
// tb_dual_joystick_key_and_mouse_mapper_top
// Drives sample items and register settings into the joystick mapper: a
// directed run at the key levels and dead zone edges, then random samples
// aimed at the hysteresis levels over several register settings and idle
// patterns, with one long result hold-off. The checker beside the block
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dual_joystick_key_and_mouse_mapper_top;
    timeunit 1ns;
    timeprecision 1ps;

    import djkm_pkg::*;

    localparam int MAX_STEP        = 8;
    localparam int SAMPLE_BITS     = 12;
    localparam int RANDOM_ITEMS    = 1240;
    localparam int NUM_PHASES      = 8;
    localparam int NUM_REGS        = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int AXIS_MAX        = 4095;

    logic              clk;
    logic              rst_n;
    logic              sample_valid;
    logic              sample_ready;
    sample_t           sample;
    logic              result_valid;
    logic              result_ready;
    result_t           result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                pending;
    int                cycle_count = 0;
    int                sender_idle_pct;
    int                receiver_stall_pct;
    logic              hold_request;
    logic              hold_off;
    logic [DATA_W-1:0] reg_shadow [NUM_REGS];
    logic [SAMPLE_W-1:0] last_rx;
    logic [SAMPLE_W-1:0] last_ry;

    dual_joystick_key_and_mouse_mapper_top #(
        .MAX_STEP    (MAX_STEP),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    djkm_checker #(
        .MAX_STEP    (MAX_STEP),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) mapper_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("dual_joystick_key_and_mouse_mapper_top regression: fail");
            $finish;
        end
    end

    // result side: random stalls, forced low during a hold-off
    initial
    begin
        result_ready = 1'b0;
    end

    always @(negedge clk)
    begin
        result_ready = !hold_off && ($urandom_range(99) >= receiver_stall_pct);
    end

    // long hold-off on the result side, counted on its own
    initial
    begin
        hold_off = 1'b0;
        wait (hold_request);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // one register access, setup then access cycle
    task automatic apb_access(logic is_write, logic [2:0] idx, logic [DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (is_write)
        begin
            reg_shadow[idx] = value;
        end
    endtask

    // offer one sample item after random idle cycles
    task automatic send_sample(sample_t s);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            sample_valid = 1'b0;
            @(negedge clk);
        end
        sample       = s;
        sample_valid = 1'b1;
        do
            @(posedge clk);
        while (!sample_ready);
        @(negedge clk);
    endtask

    task automatic send_axes(longint lx, longint ly, longint rx, longint ry, logic btn);
        sample_t s;
        s.left_x         = SAMPLE_W'(lx);
        s.left_y         = SAMPLE_W'(ly);
        s.right_x        = SAMPLE_W'(rx);
        s.right_y        = SAMPLE_W'(ry);
        s.button_pressed = btn;
        send_sample(s);
    endtask

    // drain the block before touching registers
    task automatic settle();
        sample_valid = 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] clamp_axis(longint v);
        if (v < 0)
        begin
            return '0;
        end
        if (v > AXIS_MAX)
        begin
            return SAMPLE_W'(AXIS_MAX);
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // movement axis: half the time within 3 of one of the four key levels
    function automatic logic [SAMPLE_W-1:0] movement_axis(longint c);
        longint th;
        longint hy;
        longint lvl;
        th  = reg_shadow[REG_KEY_THRESHOLD];
        hy  = reg_shadow[REG_KEY_HYSTERESIS];
        lvl = c + ($urandom_range(1) ? th : -th) + ($urandom_range(1) ? hy : -hy);
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return clamp_axis(lvl + longint'($urandom_range(6)) - 3);
            5:             return clamp_axis(c + longint'($urandom_range(40)) - 20);
            6:             return $urandom_range(1) ? SAMPLE_W'(AXIS_MAX) : '0;
            default:       return SAMPLE_W'($urandom);
        endcase
    endfunction

    // camera axis: sticky so the filter can settle, often at the dead zone edge
    function automatic logic [SAMPLE_W-1:0] camera_axis(longint c, logic [SAMPLE_W-1:0] prev);
        longint dz;
        dz = reg_shadow[REG_DEAD_ZONE];
        if ($urandom_range(99) < 70)
        begin
            return prev;
        end
        case ($urandom_range(7))
            0, 1:    return clamp_axis(c + ($urandom_range(1) ? dz : -dz)
                                       + longint'($urandom_range(2)) - 1);
            2:       return clamp_axis(c + longint'($urandom_range(60)) - 30);
            3:       return $urandom_range(1) ? SAMPLE_W'(AXIS_MAX) : '0;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_random_sample();
        sample_t s;
        s.left_x         = movement_axis(reg_shadow[REG_LEFT_X_CENTER]);
        s.left_y         = movement_axis(reg_shadow[REG_LEFT_Y_CENTER]);
        s.right_x        = camera_axis(reg_shadow[REG_RIGHT_X_CENTER], last_rx);
        s.right_y        = camera_axis(reg_shadow[REG_RIGHT_Y_CENTER], last_ry);
        s.button_pressed = 1'($urandom_range(1));
        last_rx          = s.right_x;
        last_ry          = s.right_y;
        send_sample(s);
    endtask

    // register settings per phase, extremes among them
    task automatic program_settings(int phase);
        logic [DATA_W-1:0] v [NUM_REGS];
        case (phase)
            1: v = '{4095, 4095, 4095, 4095, 4095, 1023, 4095, 255};
            2: v = '{0, 0, 0, 0, 0, 0, 0, 0};
            4: v = '{2048, 2048, 2048, 2048, 100, 600, 0, 255};
            6: v = '{0, 4095, 4095, 0, 4095, 0, 4095, 1};
            default:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    v[i] = $urandom_range(3000, 1000);
                end
                v[REG_KEY_THRESHOLD]  = $urandom_range(800);
                v[REG_KEY_HYSTERESIS] = $urandom_range(300);
                v[REG_DEAD_ZONE]      = $urandom_range(600);
                v[REG_MOUSE_GAIN]     = $urandom_range(255);
            end
        endcase
        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_access(1'b1, 3'(i), v[i]);
        end
        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_access(1'b0, 3'(i), '0);
        end
    endtask

    // directed items at reset settings: key levels, dead zone edges, saturation
    task automatic run_directed();
        longint c;
        longint t;
        longint h;
        longint d;
        c = CENTER_RST;
        t = THRESHOLD_RST;
        h = HYSTERESIS_RST;
        d = DEAD_ZONE_RST;
        send_axes(0, 0, 0, 0, 1'b0);
        send_axes(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, 1'b1);
        send_axes(c, c, c, c, 1'b0);
        // exactly on the press levels and just inside the dead zone
        send_axes(c - t - h, c + t + h, c + d - 1, c - d + 1, 1'b0);
        send_axes(c - t - h - 1, c + t + h + 1, c + d, c - d, 1'b1);
        // exactly on the release levels: keys stay held
        send_axes(c - t + h, c + t - h, c, c, 1'b1);
        send_axes(c - t + h + 1, c + t - h - 1, c, c, 1'b0);
        send_axes(c + t + h + 1, c - t - h - 1, c, c, 1'b0);
        send_axes(c + t + h, c - t - h, c, c, 1'b0);
        send_axes(c + t - h - 1, c - t + h + 1, c, c, 1'b1);
        // drive the filter into step saturation, then let it decay
        for (int i = 0; i < 6; i++)
        begin
            send_axes(c, c, AXIS_MAX, 0, 1'(i));
        end
        for (int i = 0; i < 4; i++)
        begin
            send_axes(c, c, c, c, 1'b0);
        end
        send_axes(c, c, c + d + 1, c - d - 1, 1'b1);
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n              = 1'b0;
        sample_valid       = 1'b0;
        sample             = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        hold_request       = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        last_rx            = CENTER_RST;
        last_ry            = CENTER_RST;
        for (int i = 0; i < 4; i++)
        begin
            reg_shadow[i] = DATA_W'(CENTER_RST);
        end
        reg_shadow[REG_KEY_THRESHOLD]  = DATA_W'(THRESHOLD_RST);
        reg_shadow[REG_KEY_HYSTERESIS] = DATA_W'(HYSTERESIS_RST);
        reg_shadow[REG_DEAD_ZONE]      = DATA_W'(DEAD_ZONE_RST);
        reg_shadow[REG_MOUSE_GAIN]     = DATA_W'(GAIN_RST);

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                program_settings(phase);
            end
            case (phase % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 67;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 67;
                end
                default:
                begin
                    sender_idle_pct    = 28;
                    receiver_stall_pct = 28;
                end
            endcase
            // back up the block while samples keep coming
            if (phase == 4)
            begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++)
            begin
                send_random_sample();
            end
        end

        sample_valid = 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("dual_joystick_key_and_mouse_mapper_top regression: pass");
        end
        else
        begin
            $display("dual_joystick_key_and_mouse_mapper_top regression: fail");
        end
        $finish;
    end

endmodule
